// ===== hdl/csem_pkg.sv =====
// Package for the counting semaphore table: sizes, operation and status codes,
// and the slot memory word layout.
// Used by the interfaces and the top level; depends on nothing.
package csem_pkg;

  localparam int SEM_SLOTS     = 64;
  localparam int PROCESS_SLOTS = 64;

  localparam int FUNC_W = 2;
  localparam int SID_W  = 6;
  localparam int PID_W  = 6;
  localparam int CNT_W  = 8;
  localparam int ST_W   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT    = 2'd0,
    FN_WAIT    = 2'd1,
    FN_POST    = 2'd2,
    FN_DESTROY = 2'd3
  } func_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_WOKEN     = 3'd2,
    ST_IN_USE    = 3'd3,
    ST_NO_SEM    = 3'd4,
    ST_BAD_ID    = 3'd5,
    ST_SATURATED = 3'd6
  } status_e;

  // One word of the slot memory: count and the two ends of the wait queue.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PID_W-1:0] head;
    logic [PID_W-1:0] tail;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // One result item as it is held in the output register.
  typedef struct packed {
    status_e          status;
    logic [PID_W-1:0] woken_pid;
    logic [CNT_W-1:0] count_after;
  } res_t;

endpackage

// ===== hdl/csem_req_if.sv =====
// Request channel of the semaphore table: valid/ready handshake with one item
// per accepted edge. Depends on csem_pkg for the field widths.
interface csem_req_if;
  logic                       valid;
  logic                       ready;
  logic [csem_pkg::FUNC_W-1:0] func;
  logic [csem_pkg::SID_W-1:0]  sem_id;
  logic [csem_pkg::CNT_W-1:0]  init_count;
  logic [csem_pkg::PID_W-1:0]  caller_pid;

  modport source (output valid, func, sem_id, init_count, caller_pid, input ready);
  modport sink   (input valid, func, sem_id, init_count, caller_pid, output ready);
endinterface

// ===== hdl/csem_rsp_if.sv =====
// Response channel of the semaphore table: valid/ready handshake carrying one
// result item. Depends on csem_pkg for the field widths.
interface csem_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [csem_pkg::ST_W-1:0]  status;
  logic [csem_pkg::PID_W-1:0] woken_pid;
  logic [csem_pkg::CNT_W-1:0] count_after;

  modport source (output valid, status, woken_pid, count_after, input ready);
  modport sink   (input valid, status, woken_pid, count_after, output ready);
endinterface

// ===== hdl/csem_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read that holds its data until the next read. No dependencies.
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/counting_semaphore_table_unit.sv =====
// Counting semaphore table: top level with the request sequencer, the valid
// and queue-occupied marks, and the output register.
// Depends on csem_pkg, csem_req_if, csem_rsp_if and csem_ram.
//
// Usage: a request item on req_i carries func, sem_id, init_count and
// caller_pid; each one produces exactly one result item on rsp_o with
// status, woken_pid and count_after. Requests are handled one at a time.
// The slot memory (count, queue head and tail) is read at the edge that
// accepts an item; in the slot state the answer is computed and the slot
// written back, and the result item enters the output register. A post that
// wakes a waiter while others remain queued passes through the link state as
// well, since the next-waiter link memory is read at the head just fetched
// before the new head is written. The sequencer goes back to idle as the
// result is registered and accepts a request only when idle, so it takes no
// new request before it is through with the last one.
// The output register lets a new item be accepted while a result still waits
// to be taken; if the receiver stalls, the sequencer holds its finished work
// until the output register is free, and holds off further requests.
// Reset clears all valid and queue-occupied marks at once; the memories
// need no clearing, so the block is ready as soon as reset is released.
module counting_semaphore_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  csem_req_if.sink   req_i,
  csem_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  localparam int PID_AW = $clog2(csem_pkg::PROCESS_SLOTS);

  logic [1:0] state_q, state_d;

  logic [csem_pkg::FUNC_W-1:0] func_q;
  logic [csem_pkg::SID_W-1:0]  sid_q;
  logic [csem_pkg::CNT_W-1:0]  start_q;
  logic [csem_pkg::PID_W-1:0]  pid_q;

  logic [csem_pkg::SEM_SLOTS-1:0] valid_q, valid_d;
  logic [csem_pkg::SEM_SLOTS-1:0] nonempty_q, nonempty_d;

  logic                 out_valid_q, out_valid_d;
  csem_pkg::res_t       out_q, out_d;

  // Memory ports.
  logic                        slot_we;
  logic [csem_pkg::SID_W-1:0]  slot_waddr;
  csem_pkg::slot_t             slot_wdata;
  logic                        slot_re;
  csem_pkg::slot_t             slot_rd;
  logic [csem_pkg::SLOT_W-1:0] slot_rd_raw;

  logic                        link_we;
  logic [PID_AW-1:0]           link_waddr;
  logic [csem_pkg::PID_W-1:0]  link_wdata;
  logic                        link_re;
  logic [PID_AW-1:0]           link_raddr;
  logic [csem_pkg::PID_W-1:0]  link_rd;

  logic accept;
  logic out_free;
  logic sid_bad;
  logic pid_bad;
  logic cur_valid;
  logic cur_nonempty;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  assign sid_bad      = (32'(sid_q) >= csem_pkg::SEM_SLOTS);
  assign pid_bad      = (32'(pid_q) >= csem_pkg::PROCESS_SLOTS);
  assign cur_valid    = valid_q[sid_q];
  assign cur_nonempty = nonempty_q[sid_q];

  assign slot_rd   = csem_pkg::slot_t'(slot_rd_raw);
  assign slot_re   = accept;
  assign slot_waddr = sid_q;

  csem_ram #(
    .WIDTH (csem_pkg::SLOT_W),
    .DEPTH (csem_pkg::SEM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (req_i.sem_id),
    .rdata_o (slot_rd_raw)
  );

  csem_ram #(
    .WIDTH (csem_pkg::PID_W),
    .DEPTH (csem_pkg::PROCESS_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      sid_q   <= req_i.sem_id;
      start_q <= req_i.init_count;
      pid_q   <= req_i.caller_pid;
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    nonempty_d  = nonempty_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    slot_we     = 1'b0;
    slot_wdata  = slot_rd;
    link_we     = 1'b0;
    link_waddr  = slot_rd.tail[PID_AW-1:0];
    link_wdata  = pid_q;
    link_re     = 1'b0;
    link_raddr  = slot_rd.head[PID_AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SLOT;
        end
      end

      S_SLOT: begin
        out_d.woken_pid   = '0;
        out_d.count_after = '0;
        if (sid_bad) begin
          out_d.status = csem_pkg::ST_BAD_ID;
        end else if (func_q == csem_pkg::FN_INIT) begin
          if (cur_valid) begin
            out_d.status      = csem_pkg::ST_IN_USE;
            out_d.count_after = slot_rd.count;
          end else begin
            out_d.status      = csem_pkg::ST_DONE;
            out_d.count_after = start_q;
            slot_wdata.count  = start_q;
            slot_we           = out_free;
            if (out_free) begin
              valid_d[sid_q]    = 1'b1;
              nonempty_d[sid_q] = 1'b0;
            end
          end
        end else if (func_q == csem_pkg::FN_WAIT && pid_bad) begin
          out_d.status = csem_pkg::ST_BAD_ID;
        end else if (!cur_valid) begin
          out_d.status = csem_pkg::ST_NO_SEM;
        end else if (func_q == csem_pkg::FN_WAIT) begin
          if (slot_rd.count != '0) begin
            out_d.status      = csem_pkg::ST_DONE;
            out_d.count_after = slot_rd.count - 1'b1;
            slot_wdata.count  = slot_rd.count - 1'b1;
            slot_we           = out_free;
          end else begin
            // Zero count: the caller joins the tail of the queue.
            out_d.status    = csem_pkg::ST_BLOCKED;
            slot_wdata.tail = pid_q;
            slot_we         = out_free;
            if (cur_nonempty) begin
              link_we = out_free && (32'(slot_rd.tail) < csem_pkg::PROCESS_SLOTS);
            end else begin
              slot_wdata.head = pid_q;
              if (out_free) begin
                nonempty_d[sid_q] = 1'b1;
              end
            end
          end
        end else if (func_q == csem_pkg::FN_POST) begin
          if (slot_rd.count == '0 && cur_nonempty) begin
            out_d.status    = csem_pkg::ST_WOKEN;
            out_d.woken_pid = slot_rd.head;
            if (slot_rd.head == slot_rd.tail) begin
              if (out_free) begin
                nonempty_d[sid_q] = 1'b0;
              end
            end else if (32'(slot_rd.head) >= csem_pkg::PROCESS_SLOTS) begin
              slot_wdata.head = '0;
              slot_we         = out_free;
            end else begin
              // The new head comes from the link of the one woken.
              link_re = 1'b1;
            end
          end else if (slot_rd.count == csem_pkg::CNT_MAX) begin
            out_d.status      = csem_pkg::ST_SATURATED;
            out_d.count_after = slot_rd.count;
          end else begin
            out_d.status      = csem_pkg::ST_DONE;
            out_d.count_after = slot_rd.count + 1'b1;
            slot_wdata.count  = slot_rd.count + 1'b1;
            slot_we           = out_free;
          end
        end else begin
          out_d.status = csem_pkg::ST_DONE;
          if (out_free) begin
            valid_d[sid_q]    = 1'b0;
            nonempty_d[sid_q] = 1'b0;
          end
        end

        if (!out_free) begin
          // The previous result item is still waiting; leave it untouched.
          out_d = out_q;
        end else if (link_re) begin
          state_d = S_LINK;
        end else begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_LINK: begin
        slot_wdata.head = link_rd;
        if (out_free) begin
          slot_we     = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.woken_pid   = out_q.woken_pid;
  assign rsp_o.count_after = out_q.count_after;

`ifndef SYNTHESIS
  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SLOT))
    else $error("accepted request did not move to the slot read stage");

  a_link_after_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> ($past(state_q) == S_SLOT || $past(state_q) == S_LINK))
    else $error("link stage entered without a slot stage");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_we || link_we) |-> (state_q != S_IDLE))
    else $error("memory write while no request is in flight");

  a_woken_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == csem_pkg::ST_WOKEN) |-> (rsp_o.count_after == '0))
    else $error("woken result with a nonzero count");
`endif

endmodule
